@@ hdl/hpq_pkg.sv @@
// Shared types and constants for the binary max heap priority queue unit.
package hpq_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int KEY_WIDTH_DEF = 32;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] key_in;
    } req_t;

    typedef struct packed {
        logic [31:0] max_out;
        logic        max_valid;
        logic [6:0]  count_after;
        err_t        error_code;
    } rsp_t;

    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } cell_ctrl_t;

endpackage

@@ hdl/hpq_cell.sv @@
// One storage cell of the sorted key chain: holds one key, shifts on insert and remove.
module hpq_cell #(
    parameter int KEY_WIDTH = hpq_pkg::KEY_WIDTH_DEF,
    parameter int CNT_W     = 7,
    parameter int INDEX     = 0
) (
    input  logic                   clk,
    input  hpq_pkg::cell_ctrl_t    ctrl,
    input  logic [KEY_WIDTH-1:0]   new_key,
    input  logic [KEY_WIDTH-1:0]   left_key,
    input  logic                   left_stay,
    input  logic [KEY_WIDTH-1:0]   right_key,
    input  logic [CNT_W-1:0]       count,
    output logic [KEY_WIDTH-1:0]   key,
    output logic                   stay
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 occupied;

    assign occupied = count > CNT_W'(INDEX);
    assign stay     = occupied && !(key_reg < new_key);
    assign key      = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctrl.ins_en && !stay)
        begin
            key_next = left_stay ? new_key : left_key;
        end
        else if (ctrl.rem_en)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

@@ hdl/binary_max_heap_priority_queue_unit.sv @@
// Top level of the max priority queue: chain of key cells, live count and response register.
//
// Usage:
//   Request channel (req_valid, req_ready, req): each word either inserts
//   req.key_in (mode insert) or removes the largest stored key (mode remove).
//   Response channel (rsp_valid, rsp_ready, rsp): exactly one word per request,
//   in request order, carrying the removed key, its valid flag, the key count
//   after the request and an error code (insert while full, remove while empty;
//   both leave the stored keys unchanged).
//   Keys sit in a row of CAPACITY cells kept in descending order; every cell
//   compares its key with the incoming one in the same cycle and shifts right
//   on insert or left on remove, so the largest key is always in the first cell.
//   The response is registered and appears in the cycle after the request is accepted.
//   Throughput: one request per cycle while the receiver takes each response,
//   set by the single compare-and-shift step of each cell.
//   Reset clears the key count and the response register; cell contents are
//   not cleared and are only read once written.
//   When the receiver stalls, the response is held and no further request is
//   accepted: req_ready is low while an unaccepted response waits.
module binary_max_heap_priority_queue_unit #(
    parameter int CAPACITY  = hpq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = hpq_pkg::KEY_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  hpq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output hpq_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    hpq_pkg::rsp_t        rsp_reg;
    hpq_pkg::rsp_t        rsp_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic                 accept;
    logic                 full;
    logic                 empty;
    hpq_pkg::cell_ctrl_t  ctrl;
    logic [KEY_WIDTH-1:0] new_key;
    logic [KEY_WIDTH-1:0] cell_key  [CAPACITY];
    logic                 cell_stay [CAPACITY];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = count_reg == CNT_W'(CAPACITY);
    assign empty     = count_reg == '0;
    assign new_key   = KEY_WIDTH'(req.key_in);

    assign ctrl.ins_en = accept && (req.mode == hpq_pkg::MODE_INSERT) && !full;
    assign ctrl.rem_en = accept && (req.mode == hpq_pkg::MODE_REMOVE) && !empty;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] left_key;
        logic                 left_stay;
        logic [KEY_WIDTH-1:0] right_key;

        if (i == 0)
        begin : g_first
            assign left_key  = new_key;
            assign left_stay = 1'b0;
        end
        else
        begin : g_mid
            assign left_key  = cell_key[i-1];
            assign left_stay = cell_stay[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_key = new_key;
        end
        else
        begin : g_inner
            assign right_key = cell_key[i+1];
        end

        hpq_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CNT_W),
            .INDEX     (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .new_key   (new_key),
            .left_key  (left_key),
            .left_stay (left_stay),
            .right_key (right_key),
            .count     (count_reg),
            .key       (cell_key[i]),
            .stay      (cell_stay[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.rem_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        rsp_next             = rsp_reg;
        rsp_valid_next       = rsp_valid_reg && !rsp_ready;
        if (accept)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.max_out      = ctrl.rem_en ? 32'(cell_key[0]) : '0;
            rsp_next.max_valid    = ctrl.rem_en;
            rsp_next.count_after  = 7'(count_next);
            if (req.mode == hpq_pkg::MODE_INSERT && full)
            begin
                rsp_next.error_code = hpq_pkg::ERR_FULL;
            end
            else if (req.mode == hpq_pkg::MODE_REMOVE && empty)
            begin
                rsp_next.error_code = hpq_pkg::ERR_EMPTY;
            end
            else
            begin
                rsp_next.error_code = hpq_pkg::ERR_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("key count beyond capacity");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(2) |-> !(cell_key[0] < cell_key[1]))
        else $error("first two cells out of order");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.mode == hpq_pkg::MODE_INSERT && full
        |=> rsp_reg.error_code == hpq_pkg::ERR_FULL && count_reg == $past(count_reg))
        else $error("insert while full not flagged");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.rem_en |=> rsp_reg.max_valid && count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove did not retire one key");

endmodule

@@ dv/hpq_response_checker.sv @@
// Checker for the priority queue: watches both channels, predicts each response and compares.
module hpq_response_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  hpq_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  hpq_pkg::rsp_t rsp,
    output int            mismatch_count,
    output int            outstanding
);

    localparam int CAP = hpq_pkg::CAPACITY_DEF;

    logic [31:0]   heap_keys [1:CAP];
    int            live_keys;
    hpq_pkg::rsp_t pending_responses [$];

    function automatic void swap_keys(input int a, input int b);
        logic [31:0] t;
        t            = heap_keys[a];
        heap_keys[a] = heap_keys[b];
        heap_keys[b] = t;
    endfunction

    function automatic hpq_pkg::rsp_t predict_response(input hpq_pkg::req_t w);
        hpq_pkg::rsp_t res;
        int            pos;
        int            child;
        res            = '0;
        res.error_code = hpq_pkg::ERR_OK;
        if (w.mode == hpq_pkg::MODE_INSERT)
        begin
            if (live_keys >= CAP)
            begin
                res.error_code = hpq_pkg::ERR_FULL;
            end
            else
            begin
                live_keys            = live_keys + 1;
                heap_keys[live_keys] = w.key_in;
                pos                  = live_keys;
                while (pos > 1 && heap_keys[pos / 2] < heap_keys[pos])
                begin
                    swap_keys(pos / 2, pos);
                    pos = pos / 2;
                end
            end
        end
        else
        begin
            if (live_keys == 0)
            begin
                res.error_code = hpq_pkg::ERR_EMPTY;
            end
            else
            begin
                res.max_out   = heap_keys[1];
                res.max_valid = 1'b1;
                heap_keys[1]  = heap_keys[live_keys];
                live_keys     = live_keys - 1;
                pos           = 1;
                while (2 * pos <= live_keys)
                begin
                    child = 2 * pos;
                    if (child < live_keys && heap_keys[child] < heap_keys[child + 1])
                        child = child + 1;
                    if (!(heap_keys[pos] < heap_keys[child]))
                        break;
                    swap_keys(pos, child);
                    pos = child;
                end
            end
        end
        res.count_after = live_keys[6:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hpq_pkg::rsp_t exp_word;
        if (!rst_n)
        begin
            live_keys = 0;
            pending_responses.delete();
            mismatch_count = 0;
            outstanding    = 0;
        end
        else
        begin
            if (req_valid && req_ready)
                pending_responses.push_back(predict_response(req));
            if (rsp_valid && rsp_ready)
            begin
                if (pending_responses.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected response word: %h", rsp);
                end
                else
                begin
                    exp_word = pending_responses.pop_front();
                    if (rsp.max_out !== exp_word.max_out
                        || rsp.max_valid !== exp_word.max_valid
                        || rsp.count_after !== exp_word.count_after
                        || rsp.error_code !== exp_word.error_code)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp %h %b %0d %0d, got %h %b %0d %0d",
                                     exp_word.max_out, exp_word.max_valid,
                                     exp_word.count_after, exp_word.error_code,
                                     rsp.max_out, rsp.max_valid,
                                     rsp.count_after, rsp.error_code);
                    end
                end
            end
            outstanding = pending_responses.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
// Top of the priority queue testbench: clock, reset, request and response stimulus, verdict.
module testbench;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    hpq_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    hpq_pkg::rsp_t rsp;
    int            mismatch_count;
    int            outstanding;
    int            words_sent;
    logic          calm;

    binary_max_heap_priority_queue_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    hpq_response_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign calm = (words_sent >= 700 && words_sent < 1000);

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= calm || ($urandom_range(99) >= 11);
    end

    function automatic hpq_pkg::req_t make_word(input hpq_pkg::mode_t m,
                                                input logic [31:0] k);
        hpq_pkg::req_t w;
        w.mode   = m;
        w.key_in = k;
        return w;
    endfunction

    function automatic logic [31:0] rand_key();
        case ($urandom_range(3))
            0:       return 32'($urandom_range(0, 7));
            1:       return 32'hFFFF_FFF8 + 32'($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_word(input hpq_pkg::req_t w);
        if (!calm && $urandom_range(99) < 11)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        do @(negedge clk); while (!req_ready);
        @(posedge clk);
        words_sent = words_sent + 1;
    endtask

    task automatic send_phase(input int len, input int insert_pct);
        hpq_pkg::mode_t m;
        for (int i = 0; i < len; i++)
        begin
            m = ($urandom_range(99) < insert_pct) ? hpq_pkg::MODE_INSERT
                                                  : hpq_pkg::MODE_REMOVE;
            send_word(make_word(m, m == hpq_pkg::MODE_INSERT ? rand_key()
                                                              : $urandom()));
        end
    endtask

    initial
    begin
        int wait_cycles;
        int random_target;
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        req        <= '0;
        words_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(make_word(hpq_pkg::MODE_REMOVE, 32'hFFFF_FFFF));
        send_word(make_word(hpq_pkg::MODE_INSERT, 32'h0000_0000));
        send_word(make_word(hpq_pkg::MODE_INSERT, 32'hFFFF_FFFF));
        send_word(make_word(hpq_pkg::MODE_INSERT, 32'h0000_0000));
        send_word(make_word(hpq_pkg::MODE_INSERT, 32'h8000_0000));
        send_word(make_word(hpq_pkg::MODE_INSERT, 32'h0000_0005));
        send_word(make_word(hpq_pkg::MODE_INSERT, 32'h0000_0005));
        send_word(make_word(hpq_pkg::MODE_INSERT, 32'h0000_0005));
        send_word(make_word(hpq_pkg::MODE_INSERT, 32'h7FFF_FFFF));
        for (int i = 0; i < 8; i++)
            send_word(make_word(hpq_pkg::MODE_REMOVE, $urandom()));
        send_word(make_word(hpq_pkg::MODE_REMOVE, 32'h0000_0000));
        send_word(make_word(hpq_pkg::MODE_INSERT, 32'h0000_0007));
        send_word(make_word(hpq_pkg::MODE_INSERT, 32'h0000_0007));
        send_word(make_word(hpq_pkg::MODE_REMOVE, 32'h0000_0000));
        send_word(make_word(hpq_pkg::MODE_REMOVE, 32'h0000_0000));

        random_target = words_sent + 1650;
        send_phase(70, 100);
        send_phase(70, 0);
        while (words_sent < random_target)
        begin
            case ($urandom_range(2))
                0:       send_phase($urandom_range(20, 120), 85);
                1:       send_phase($urandom_range(20, 120), 15);
                default: send_phase($urandom_range(20, 120), 50);
            endcase
        end
        req_valid <= 1'b0;

        wait_cycles = 0;
        while (outstanding != 0 && wait_cycles < 200000)
        begin
            @(negedge clk);
            wait_cycles = wait_cycles + 1;
        end
        if (outstanding != 0)
        begin
            $display("testbench NOT OK");
        end
        else
        begin
            repeat (20) @(posedge clk);
            if (mismatch_count == 0 && outstanding == 0)
                $display("testbench OK");
            else
                $display("testbench NOT OK");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
